FILE: design/rsst_pkg.sv
// Shared types, constants and register codes for the running statistics tracker.
`default_nettype none
package rsst_pkg;

	localparam int AccW = 160;
	localparam int FacW = 80;
	localparam int LenW = 7;
	localparam int DvsW = 17;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_MERGE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] REG_TOL = 2'd0;
	localparam logic [1:0] REG_MIN_SMP = 2'd1;
	localparam logic [1:0] REG_MIN_TOT = 2'd2;
	localparam logic [1:0] REG_BY_INV = 2'd3;

	localparam logic [15:0] TOL_RESET = 16'd6554;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam logic [63:0] VAR_DEFAULT = 64'd1000000;
	localparam logic [11:0] K_LHS = 12'd2401;
	localparam logic [9:0] K_RHS = 10'd625;

	typedef enum logic {
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
		logic [AccW-1:0] a;
		logic [FacW-1:0] b;
		logic [LenW-1:0] len;
	} alu_cmd_t;

	typedef struct packed {
		logic done;
		logic [AccW-1:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic [15:0] tol;
		logic [15:0] min_smp;
		logic [39:0] min_tot;
		logic by_inv;
	} cfg_t;

endpackage
`default_nettype wire

FILE: design/running_stats_steadiness_tracker.sv
// Running statistics tracker top level: sequencer, statistics state and output register.
//
// Input beats arrive on s_t*; s_tuser carries the operation (add, merge, clear) and
// s_tdata the sample and the remote statistics. Every accepted beat yields exactly
// one result beat on m_t*: count, mean (Q24.16), squared-deviation sum, and the
// steady and active flags in m_tuser. Registers are written over the APB port.
// One beat is worked on at a time; s_tready is high only while the sequencer is idle.
// All products and quotients go through one bit-serial multiply/divide unit that
// handles one operand bit per cycle, so latency is set by the operand lengths: an
// add runs four unit operations, a merge seven, and the steadiness test eight more
// while not yet steady (also after a clear); an add while already steady runs none.
// Reset clears the statistics and the steady flag and loads the register defaults.
// When the receiver stalls, the result waits in the output register; a new input
// beat may be taken meanwhile, and its result waits until the output is free.
`default_nettype none
module running_stats_steadiness_tracker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// [23:0] sample_time, [39:24] remote_count, [79:40] remote_mean,
	// [143:80] remote_sq_dev
	input  wire logic [143:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0] s_tuser,
	output logic m_tvalid,
	input  wire logic m_tready,
	// [15:0] count, [55:16] mean, [119:56] sq_dev_sum
	output logic [119:0] m_tdata,
	// [0] steady, [1] active
	output logic [1:0] m_tuser,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISP,
		ST_A_DIVQ,
		ST_A_SQ,
		ST_A_MULN,
		ST_A_DIVS,
		ST_M_SQ,
		ST_M_N1,
		ST_M_N2,
		ST_M_DIVS,
		ST_M_R1,
		ST_M_R2,
		ST_M_DIVM,
		ST_TST,
		ST_T_LHS,
		ST_T_TOL1,
		ST_T_TOL2,
		ST_T_M1,
		ST_T_M2,
		ST_T_N,
		ST_T_D,
		ST_T_MC,
		ST_FIN
	} state_t;

	rsst_pkg::cfg_t cfg;
	rsst_pkg::alu_cmd_t cmd_q;
	rsst_pkg::alu_rsp_t rsp;

	state_t state_q;
	logic [1:0] op_q;
	logic [23:0] smp_q;
	logic [15:0] n1_q;
	logic [39:0] rmean_q;
	logic [63:0] rsq_q;

	logic [15:0] cnt_q;
	logic [15:0] inv_q;
	logic [39:0] mean_q;
	logic [63:0] sq_q;
	logic steady_q;

	logic [39:0] mag_q;
	logic neg_q;
	logic [75:0] lhs_q;
	logic [55:0] m1_q;
	logic c1_q;

	logic m_tvalid_q;
	logic [119:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic [39:0] x;
	logic [39:0] mmag;
	logic [16:0] tot;
	logic [15:0] cnt_inc;
	logic [16:0] cnt_sum;
	logic [15:0] den;
	logic [15:0] nsel;
	logic [63:0] vsel;
	logic [56:0] num;
	logic [63:0] qsat;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic rsst_pkg::alu_cmd_t mk(input rsst_pkg::alu_op_t op,
			input logic [rsst_pkg::AccW-1:0] a, input logic [rsst_pkg::FacW-1:0] b,
			input logic [rsst_pkg::LenW-1:0] len);
		rsst_pkg::alu_cmd_t c;
		c.start = 1'b1;
		c.op = op;
		c.a = a;
		c.b = b;
		c.len = len;
		return c;
	endfunction

	rsst_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	rsst_alu u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_q),
		.rsp(rsp)
	);

	always_comb begin
		x = {smp_q, 16'd0};
		mmag = (mean_q >= rmean_q) ? mean_q - rmean_q : rmean_q - mean_q;
		tot = {1'b0, n1_q} + {1'b0, cnt_q};
		cnt_inc = (cnt_q == rsst_pkg::CNT_MAX) ? cnt_q : cnt_q + 16'd1;
		cnt_sum = {1'b0, cnt_q} + {1'b0, n1_q};
		den = (cnt_q > 16'd1) ? cnt_q - 16'd1 : 16'd1;
		nsel = cfg.by_inv ? inv_q : 16'd1;
		vsel = (cnt_q > 16'd1) ? sq_q : rsst_pkg::VAR_DEFAULT;
		num = {1'b0, m1_q} + {1'b0, rsp.res[55:0]};
		qsat = (rsp.res[79:64] != 16'd0) ? '1 : rsp.res[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q.start <= 1'b0;
			cnt_q <= '0;
			inv_q <= '0;
			mean_q <= '0;
			sq_q <= '0;
			steady_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cmd_q.start <= 1'b0;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					priority case (op_q)
						rsst_pkg::OP_ADD: begin
							if (!steady_q) begin
								cnt_q <= cnt_inc;
								inv_q <= (inv_q == rsst_pkg::CNT_MAX) ? inv_q : inv_q + 16'd1;
								neg_q <= x < mean_q;
								mag_q <= (x < mean_q) ? mean_q - x : x - mean_q;
								cmd_q <= mk(rsst_pkg::ALU_DIV, {144'd0, cnt_inc},
									{((x < mean_q) ? mean_q - x : x - mean_q), 40'd0}, 7'd40);
								state_q <= ST_A_DIVQ;
							end else begin
								state_q <= ST_TST;
							end
						end
						rsst_pkg::OP_MERGE: begin
							if (tot != 17'd0) begin
								mag_q <= mmag;
								cmd_q <= mk(rsst_pkg::ALU_MUL, {120'd0, mmag}, {mmag, 40'd0}, 7'd40);
								state_q <= ST_M_SQ;
							end else begin
								state_q <= ST_TST;
							end
						end
						rsst_pkg::OP_CLEAR: begin
							cnt_q <= '0;
							inv_q <= '0;
							mean_q <= '0;
							sq_q <= '0;
							steady_q <= 1'b0;
							state_q <= ST_TST;
						end
						default: begin
							state_q <= ST_TST;
						end
					endcase
				end
				ST_A_DIVQ: begin
					if (rsp.done) begin
						mean_q <= neg_q ? mean_q - rsp.res[39:0] : mean_q + rsp.res[39:0];
						cmd_q <= mk(rsst_pkg::ALU_MUL, {120'd0, mag_q}, {mag_q, 40'd0}, 7'd40);
						state_q <= ST_A_SQ;
					end
				end
				ST_A_SQ: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {cnt_q - 16'd1, 64'd0}, 7'd16);
						state_q <= ST_A_MULN;
					end
				end
				ST_A_MULN: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_DIV, {144'd0, cnt_q},
							{rsp.res[95:32], 16'd0}, 7'd64);
						state_q <= ST_A_DIVS;
					end
				end
				ST_A_DIVS: begin
					if (rsp.done) begin
						sq_q <= sat_add(sq_q, rsp.res[63:0]);
						state_q <= ST_TST;
					end
				end
				ST_M_SQ: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {n1_q, 64'd0}, 7'd16);
						state_q <= ST_M_N1;
					end
				end
				ST_M_N1: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {cnt_q, 64'd0}, 7'd16);
						state_q <= ST_M_N2;
					end
				end
				ST_M_N2: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_DIV, {143'd0, tot}, rsp.res[111:32], 7'd80);
						state_q <= ST_M_DIVS;
					end
				end
				ST_M_DIVS: begin
					if (rsp.done) begin
						sq_q <= sat_add(sat_add(rsq_q, sq_q), qsat);
						cmd_q <= mk(rsst_pkg::ALU_MUL, {120'd0, rmean_q}, {n1_q, 64'd0}, 7'd16);
						state_q <= ST_M_R1;
					end
				end
				ST_M_R1: begin
					if (rsp.done) begin
						m1_q <= rsp.res[55:0];
						cmd_q <= mk(rsst_pkg::ALU_MUL, {120'd0, mean_q}, {cnt_q, 64'd0}, 7'd16);
						state_q <= ST_M_R2;
					end
				end
				ST_M_R2: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_DIV, {143'd0, tot}, {num, 23'd0}, 7'd57);
						state_q <= ST_M_DIVM;
					end
				end
				ST_M_DIVM: begin
					if (rsp.done) begin
						mean_q <= rsp.res[39:0];
						cnt_q <= cnt_sum[16] ? rsst_pkg::CNT_MAX : cnt_sum[15:0];
						state_q <= ST_TST;
					end
				end
				ST_TST: begin
					if (steady_q) begin
						state_q <= ST_FIN;
					end else begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, {96'd0, vsel}, {rsst_pkg::K_LHS, 68'd0},
							7'd12);
						state_q <= ST_T_LHS;
					end
				end
				ST_T_LHS: begin
					if (rsp.done) begin
						lhs_q <= rsp.res[75:0];
						cmd_q <= mk(rsst_pkg::ALU_MUL, {150'd0, rsst_pkg::K_RHS},
							{cfg.tol, 64'd0}, 7'd16);
						state_q <= ST_T_TOL1;
					end
				end
				ST_T_TOL1: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {cfg.tol, 64'd0}, 7'd16);
						state_q <= ST_T_TOL2;
					end
				end
				ST_T_TOL2: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {mean_q, 40'd0}, 7'd40);
						state_q <= ST_T_M1;
					end
				end
				ST_T_M1: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {mean_q, 40'd0}, 7'd40);
						state_q <= ST_T_M2;
					end
				end
				ST_T_M2: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {nsel, 64'd0}, 7'd16);
						state_q <= ST_T_N;
					end
				end
				ST_T_N: begin
					if (rsp.done) begin
						cmd_q <= mk(rsst_pkg::ALU_MUL, rsp.res, {den, 64'd0}, 7'd16);
						state_q <= ST_T_D;
					end
				end
				ST_T_D: begin
					if (rsp.done) begin
						c1_q <= {20'd0, lhs_q, 64'd0} < rsp.res;
						cmd_q <= mk(rsst_pkg::ALU_MUL, {120'd0, mean_q}, {cnt_q, 64'd0}, 7'd16);
						state_q <= ST_T_MC;
					end
				end
				ST_T_MC: begin
					if (rsp.done) begin
						steady_q <= c1_q && (cnt_q >= cfg.min_smp)
							&& (rsp.res[55:0] >= {cfg.min_tot, 16'd0});
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			op_q <= s_tuser;
			smp_q <= s_tdata[23:0];
			n1_q <= s_tdata[39:24];
			rmean_q <= s_tdata[79:40];
			rsq_q <= s_tdata[143:80];
		end
		if (state_q == ST_FIN && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {sq_q, mean_q, cnt_q};
			m_tuser_q <= {!steady_q, steady_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

endmodule
`default_nettype wire

FILE: design/rsst_alu.sv
// Shared bit-serial multiply and restoring divide unit, one operand bit per cycle.
`default_nettype none
module rsst_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire rsst_pkg::alu_cmd_t cmd,
	output rsst_pkg::alu_rsp_t rsp
);

	logic busy_q;
	logic done_q;
	rsst_pkg::alu_op_t op_q;
	logic [rsst_pkg::AccW-1:0] x_q;
	logic [rsst_pkg::FacW-1:0] f_q;
	logic [rsst_pkg::LenW-1:0] cnt_q;
	logic [rsst_pkg::AccW-1:0] acc_q;
	logic [rsst_pkg::DvsW-1:0] rem_q;

	logic [rsst_pkg::DvsW:0] rtry;
	logic ge;
	logic [rsst_pkg::DvsW:0] rdiff;
	logic [rsst_pkg::AccW-1:0] macc;

	always_comb begin
		rtry = {rem_q, f_q[rsst_pkg::FacW-1]};
		ge = rtry >= {1'b0, x_q[rsst_pkg::DvsW-1:0]};
		rdiff = rtry - {1'b0, x_q[rsst_pkg::DvsW-1:0]};
		macc = {acc_q[rsst_pkg::AccW-2:0], 1'b0}
			+ (f_q[rsst_pkg::FacW-1] ? x_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q <= rsst_pkg::ALU_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				cnt_q <= cmd.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= cmd.a;
			f_q <= cmd.b;
			acc_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			f_q <= {f_q[rsst_pkg::FacW-2:0], 1'b0};
			unique case (op_q)
				rsst_pkg::ALU_MUL: begin
					acc_q <= macc;
				end
				rsst_pkg::ALU_DIV: begin
					rem_q <= ge ? rdiff[rsst_pkg::DvsW-1:0] : rtry[rsst_pkg::DvsW-1:0];
					acc_q <= {acc_q[rsst_pkg::AccW-2:0], ge};
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res = acc_q;

endmodule
`default_nettype wire

FILE: design/rsst_cfg.sv
// APB register file for tolerance, minimum count, minimum total time and mode.
`default_nettype none
module rsst_cfg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [4:0] paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	output rsst_pkg::cfg_t cfg
);

	rsst_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tol <= rsst_pkg::TOL_RESET;
			cfg_q.min_smp <= '0;
			cfg_q.min_tot <= '0;
			cfg_q.by_inv <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:3])
				rsst_pkg::REG_TOL: cfg_q.tol <= pwdata[15:0];
				rsst_pkg::REG_MIN_SMP: cfg_q.min_smp <= pwdata[15:0];
				rsst_pkg::REG_MIN_TOT: cfg_q.min_tot <= pwdata[39:0];
				rsst_pkg::REG_BY_INV: cfg_q.by_inv <= pwdata[0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			rsst_pkg::REG_TOL: prdata = {48'd0, cfg_q.tol};
			rsst_pkg::REG_MIN_SMP: prdata = {48'd0, cfg_q.min_smp};
			rsst_pkg::REG_MIN_TOT: prdata = {24'd0, cfg_q.min_tot};
			rsst_pkg::REG_BY_INV: prdata = {63'd0, cfg_q.by_inv};
		endcase
	end

	assign pready = 1'b1;
	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: design/rsst_chk.sv
// Port-level checker for the running statistics tracker, bound to the top level.
`default_nettype none
module rsst_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [119:0] m_tdata,
	input wire logic [1:0] m_tuser
);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a beat is in work");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] != m_tuser[1]))
		else $error("steady and active not complementary");

	a_empty_stats: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[15:0] == 16'd0) |-> (m_tdata[119:16] == 104'd0))
		else $error("zero count with nonzero mean or deviation sum");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

endmodule

bind running_stats_steadiness_tracker rsst_chk u_rsst_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);
`default_nettype wire

FILE: verif/tb_running_stats_steadiness_tracker.sv
// Testbench for the running statistics tracker: random and directed beats against a predictor.
module tb_running_stats_steadiness_tracker;
	import rsst_pkg::*;

	localparam int LIMIT = 4_000_000;
	localparam int RUN_ITEMS = 1350;
	localparam int PHASES = 6;

	typedef struct {
		logic [15:0] count;
		logic [39:0] mean;
		logic [63:0] sq_dev;
		logic steady;
		logic active;
	} stats_t;

	class stats_board;
		logic [15:0] tol, min_smp;
		logic [39:0] min_tot;
		logic by_inv;
		logic [15:0] cnt, inv;
		logic [39:0] mean;
		logic [63:0] sq;
		logic stdy, act;
		stats_t pending[$];
		int errors, results, steady_seen;

		function new();
			tol = TOL_RESET;
			min_smp = 0;
			min_tot = 0;
			by_inv = 0;
			clear_stats();
			errors = 0;
			results = 0;
			steady_seen = 0;
		endfunction

		function void clear_stats();
			cnt = 0;
			inv = 0;
			mean = 0;
			sq = 0;
			stdy = 0;
			act = 1;
		endfunction

		function void set_reg(logic [1:0] idx, logic [63:0] v);
			case (idx)
				REG_TOL: tol = v[15:0];
				REG_MIN_SMP: min_smp = v[15:0];
				REG_MIN_TOT: min_tot = v[39:0];
				REG_BY_INV: by_inv = v[0];
				default: ;
			endcase
		endfunction

		function logic [63:0] sat64(logic [255:0] v);
			return (v[255:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
		endfunction

		function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
			logic [64:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
		endfunction

		function logic steady_test();
			logic [63:0] v;
			logic [15:0] den, n;
			logic [255:0] lhs, rhs;
			logic [63:0] tot_lhs, tot_rhs;
			v = (cnt > 1) ? sq : VAR_DEFAULT;
			den = (cnt > 1) ? cnt - 16'd1 : 16'd1;
			n = by_inv ? inv : 16'd1;
			lhs = (256'(v) * 256'(K_LHS)) << 64;
			rhs = 256'(K_RHS) * 256'(tol) * 256'(tol) * 256'(mean) * 256'(mean)
				* 256'(n) * 256'(den);
			tot_lhs = 64'(mean) * 64'(cnt);
			tot_rhs = {8'd0, min_tot, 16'd0};
			return (lhs < rhs) && (cnt >= min_smp) && (tot_lhs >= tot_rhs);
		endfunction

		function void note_beat(logic [1:0] op, logic [143:0] d);
			logic [39:0] x, mag, q, rm;
			logic [15:0] n, rc;
			logic [16:0] tot;
			logic [255:0] prod;
			logic [63:0] msum;
			logic neg;
			stats_t e;
			rc = d[39:24];
			rm = d[79:40];
			case (op)
				OP_ADD: begin
					if (act) begin
						if (cnt != CNT_MAX) cnt = cnt + 1;
						if (inv != CNT_MAX) inv = inv + 1;
						n = cnt;
						x = {d[23:0], 16'd0};
						neg = x < mean;
						mag = neg ? mean - x : x - mean;
						q = mag / n;
						mean = neg ? mean - q : mean + q;
						prod = 256'(mag) * 256'(mag) * 256'(n - 16'd1);
						sq = sat_add(sq, sat64(prod / (256'(n) << 32)));
					end
				end
				OP_MERGE: begin
					tot = 17'(rc) + 17'(cnt);
					if (tot != 0) begin
						mag = (mean >= rm) ? mean - rm : rm - mean;
						prod = 256'(mag) * 256'(mag) * 256'(rc) * 256'(cnt);
						sq = sat_add(sat_add(d[143:80], sq), sat64(prod / (256'(tot) << 32)));
						msum = 64'(rc) * 64'(rm) + 64'(cnt) * 64'(mean);
						mean = 40'(msum / 64'(tot));
						cnt = (tot > 17'(CNT_MAX)) ? CNT_MAX : tot[15:0];
					end
				end
				OP_CLEAR: clear_stats();
				default: ;
			endcase
			if (!stdy) stdy = steady_test();
			act = !stdy;
			e.count = cnt;
			e.mean = mean;
			e.sq_dev = sq;
			e.steady = stdy;
			e.active = act;
			pending.push_back(e);
		endfunction

		function void check_beat(logic [119:0] d, logic [1:0] u);
			stats_t e;
			results++;
			if (u[0]) steady_seen++;
			if (pending.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[15:0] !== e.count) begin
				$error("count: expected %0d, got %0d", e.count, d[15:0]);
				errors++;
			end
			if (d[55:16] !== e.mean) begin
				$error("mean: expected %0h, got %0h", e.mean, d[55:16]);
				errors++;
			end
			if (d[119:56] !== e.sq_dev) begin
				$error("sq_dev_sum: expected %0h, got %0h", e.sq_dev, d[119:56]);
				errors++;
			end
			if (u[0] !== e.steady) begin
				$error("steady: expected %0d, got %0d", e.steady, u[0]);
				errors++;
			end
			if (u[1] !== e.active) begin
				$error("active: expected %0d, got %0d", e.active, u[1]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready;
	logic [143:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid, m_tready;
	logic [119:0] m_tdata;
	logic [1:0] m_tuser;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [63:0] pwdata, prdata;

	stats_board sb;
	bit calm, hold_req;
	int cycles, sent;

	running_stats_steadiness_tracker DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [63:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'd0};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic configure(logic [15:0] tol, logic [15:0] ms, logic [39:0] mt, logic bi);
		reg_write(REG_TOL, 64'(tol));
		reg_write(REG_MIN_SMP, 64'(ms));
		reg_write(REG_MIN_TOT, 64'(mt));
		reg_write(REG_BY_INV, 64'(bi));
	endtask

	task automatic send(logic [1:0] op, logic [23:0] t, logic [15:0] rc, logic [39:0] rm,
			logic [63:0] rq);
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {rq, rm, rc, t};
		forever begin
			@(negedge clk);
			if (s_tready) break;
		end
		@(posedge clk);
		sb.note_beat(op, {rq, rm, rc, t});
		sent++;
		if (!calm && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic directed();
		send(OP_MERGE, 0, 0, 40'hFF_FFFF_FFFF, rand64());
		send(OP_ADD, 24'd0, 0, 0, 0);
		send(OP_ADD, 24'hFF_FFFF, 0, 0, 0);
		send(OP_ADD, 24'd0, 0, 0, 0);
		send(2'd3, $urandom, $urandom, rand64(), rand64());
		send(OP_MERGE, 0, 16'hFFFF, 40'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send(OP_ADD, 24'hFF_FFFF, 0, 0, 0);
		send(OP_ADD, 24'd1, 0, 0, 0);
		send(OP_MERGE, 0, 16'hFFFF, 40'd0, 64'd0);
		send(OP_CLEAR, $urandom, $urandom, rand64(), rand64());
		for (int i = 0; i < 8; i++)
			send(OP_ADD, 24'd5000 + 24'(i % 2), 0, 0, 0);
		send(OP_ADD, 24'd5000, 0, 0, 0);
		send(OP_MERGE, 0, 16'd10, {24'd5000, 16'd0}, 64'd3);
		send(OP_CLEAR, 0, 0, 0, 0);
		send(OP_MERGE, 0, 16'd1, 40'h12_3456, 64'd0);
	endtask

	task automatic random_run(int items);
		logic [23:0] base, t;
		logic [15:0] jit;
		int k;
		base = $urandom;
		jit = 16'(1 << $urandom_range(0, 12));
		for (int i = 0; i < items; i++) begin
			if (sent > 1150) calm = 1;
			k = $urandom_range(0, 99);
			t = base + 24'($urandom_range(0, jit));
			if (k < 8) begin
				send(OP_CLEAR, $urandom, $urandom, rand64(), rand64());
				base = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 4000));
				jit = 16'(1 << $urandom_range(0, 12));
			end else if (k < 18) begin
				send(OP_MERGE, $urandom, 16'($urandom_range(0, 40)), {t, 16'($urandom)},
					64'($urandom_range(0, 100000)));
			end else if (k < 28) begin
				send(2'($urandom), $urandom, $urandom, rand64(), rand64());
			end else begin
				send(OP_ADD, t, $urandom, rand64(), rand64());
			end
		end
	endtask

	initial begin
		int stall;
		stall = 0;
		m_tready = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(0, 6);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
			@(negedge clk);
			if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
		end
	end

	initial begin
		sb = new();
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		calm = 0;
		hold_req = 0;
		sent = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		drain();
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: configure(16'hFFFF, 16'd0, 40'd0, 1'b1);
				2: configure(16'd0, 16'hFFFF, 40'hFF_FFFF_FFFF, 1'b0);
				3: configure(16'($urandom), 16'($urandom_range(0, 30)),
					40'($urandom_range(0, 200000)), 1'b0);
				4: configure(16'hFFFF, 16'd5, 40'd1000, 1'b1);
				default: configure(TOL_RESET, 16'd0, 40'd0, 1'b0);
			endcase
			if (p == 1) hold_req = 1;
			random_run(RUN_ITEMS / (2 * PHASES));
			if (p == 3) drain();
			random_run(RUN_ITEMS / (2 * PHASES));
			drain();
		end
		repeat (400) @(posedge clk);
		$display("Covered %0d input beats over %0d register settings; %0d results, %0d steady.",
			sent, PHASES, sb.results, sb.steady_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
